### rtl/ddd_pkg.sv
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, constants and calendar tables for the Gregorian day count.
// ----------------------------------------------------------------------------
package ddd_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int NUM_W   = 22;   // day number, 0001-01-01 is day 1
   localparam int DBM_W   = 9;    // days before month, up to 334

   localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;

   // floor(p / 100) = (p * 5243) >> 19, exact for p below 2^14
   localparam int                 DIV100_W     = 27;
   localparam logic [DIV100_W-1:0] DIV100_MUL  = 27'd5243;
   localparam int                 DIV100_SHIFT = 19;
   localparam int                 QUOT_W       = 7;   // p / 100 is at most 99
   localparam logic [QUOT_W-1:0]  REM_CENTURY  = 7'd99;

   localparam logic [NUM_W-1:0]   DAYS_PER_YEAR = 22'd365;

   // configuration register indexes
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_REF_DAY   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_REF_MONTH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REF_YEAR  = 2'd2;

   localparam logic [DAY_W-1:0]   REF_DAY_RESET   = 5'd17;
   localparam logic [MONTH_W-1:0] REF_MONTH_RESET = 4'd9;
   localparam logic [YEAR_W-1:0]  REF_YEAR_RESET  = 14'd2020;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   // load enables of the four day-number stages
   typedef struct packed {
      logic s4;
      logic s3;
      logic s2;
      logic s1;
   } stage_en_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DBM_W-1:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

### rtl/date_difference_days_unit.sv
// Takes one date per cycle while the rsp side does not stall; an accepted req beat passes
// through a five-stage register chain to rsp_tvalid: four day-number stages and the
// compare/output stage. Each stage holds its own valid bit and loads when it is empty
// or its successor moves, so bubbles close up under a stalled rsp side.
// Synchronous reset clears every valid bit and loads the reference date 2020-09-17.
// ----------------------------------------------------------------------------
// date_difference_days_unit
// Inclusive Gregorian day count from each streamed start date to a reference date.
// ----------------------------------------------------------------------------
module date_difference_days_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // in_day, in_month, in_year, pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // day_count, pad
   output logic                              rsp_tuser,  // order_error
   input  logic                              csr_we,
   input  logic [ddd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ddd_pkg::YEAR_W-1:0]        csr_wdata
);

   localparam int STAGES = 5;

   logic [ddd_pkg::DAY_W-1:0]   ref_day_ff;
   logic [ddd_pkg::MONTH_W-1:0] ref_month_ff;
   logic [ddd_pkg::YEAR_W-1:0]  ref_year_ff;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] stage_rdy;

   ddd_pkg::stage_en_type stage_en;
   ddd_pkg::date_type     from_date, stop_date;
   logic [ddd_pkg::NUM_W-1:0] start_num, stop_num;

   logic [ddd_pkg::NUM_W-1:0] count_ff, count_in;
   logic                      order_err_ff, order_err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_day_ff   <= ddd_pkg::REF_DAY_RESET;
         ref_month_ff <= ddd_pkg::REF_MONTH_RESET;
         ref_year_ff  <= ddd_pkg::REF_YEAR_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            ddd_pkg::CSR_REF_DAY:   ref_day_ff   <= csr_wdata[ddd_pkg::DAY_W-1:0];
            ddd_pkg::CSR_REF_MONTH: ref_month_ff <= csr_wdata[ddd_pkg::MONTH_W-1:0];
            ddd_pkg::CSR_REF_YEAR:  ref_year_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage may load when it is empty or its content moves on
   always_comb begin
      stage_rdy[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_rdy[i] = !valid_ff[i] || stage_rdy[i+1];
      end
      valid_in[0] = stage_rdy[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = stage_rdy[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready  = stage_rdy[0];
   assign stage_en.s1 = stage_rdy[0];
   assign stage_en.s2 = stage_rdy[1];
   assign stage_en.s3 = stage_rdy[2];
   assign stage_en.s4 = stage_rdy[3];

   assign from_date.day   = req_tdata[4:0];
   assign from_date.month = req_tdata[8:5];
   assign from_date.year  = req_tdata[22:9];

   // the reference enters with each beat, so a beat always sees the registers
   // as they stood when it was taken
   assign stop_date.day   = ref_day_ff;
   assign stop_date.month = ref_month_ff;
   assign stop_date.year  = ref_year_ff;

   ddd_day_number u_start_num (
      .clock    (clock),
      .stage_en (stage_en),
      .date_in  (from_date),
      .day_num  (start_num)
   );

   ddd_day_number u_stop_num (
      .clock    (clock),
      .stage_en (stage_en),
      .date_in  (stop_date),
      .day_num  (stop_num)
   );

   always_comb begin
      order_err_in = start_num > stop_num;
      if (order_err_in) begin
         count_in = '0;
      end else begin
         count_in = stop_num - start_num + ddd_pkg::NUM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[STAGES-1]) begin
         count_ff     <= count_in;
         order_err_ff <= order_err_in;
      end
   end

   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {2'b00, count_ff};
   assign rsp_tuser  = order_err_ff;

`ifndef NO_ASSERTIONS
   a_err_zero_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("order error beat with a nonzero count");

   a_ok_nonzero_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata != '0))
      else $error("in-order beat with a zero count");

   a_full_blocks_req : assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("full pipeline took a req beat under stall");

   a_reset_clears : assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("valid bits not cleared by reset");

   a_stall_holds_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(count_ff)
                                       && $stable(order_err_ff)))
      else $error("stalled result changed inside the output stage");
`endif

endmodule

### rtl/ddd_day_number.sv
// ----------------------------------------------------------------------------
// ddd_day_number
// Four-stage pipeline from a raw date to its closed-form Gregorian day number.
// ----------------------------------------------------------------------------
module ddd_day_number (
   input  logic                          clock,
   input  ddd_pkg::stage_en_type         stage_en,
   input  ddd_pkg::date_type             date_in,
   output logic [ddd_pkg::NUM_W-1:0]     day_num
);

   // stage 1: clamp year and month, form p = year - 1
   logic [ddd_pkg::YEAR_W-1:0]  s1_p_ff,     s1_p_in;
   logic [ddd_pkg::MONTH_W-1:0] s1_month_ff, s1_month_in;
   logic [ddd_pkg::DAY_W-1:0]   s1_day_ff;

   // stage 2: reciprocal product and 365 * p
   logic [ddd_pkg::DIV100_W-1:0] s2_prod_ff, s2_prod_in;
   logic [ddd_pkg::NUM_W-1:0]    s2_p365_ff, s2_p365_in;
   logic [ddd_pkg::YEAR_W-1:0]   s2_p_ff;
   logic [ddd_pkg::MONTH_W-1:0]  s2_month_ff;
   logic [ddd_pkg::DAY_W-1:0]    s2_day_ff;

   // stage 3: century quotient, leap flag, clamp day
   logic [ddd_pkg::QUOT_W-1:0]  s3_q100_ff, s3_q100_in;
   logic [ddd_pkg::NUM_W-1:0]   s3_base_ff, s3_base_in;
   logic [ddd_pkg::DBM_W-1:0]   s3_dbm_ff,  s3_dbm_in;
   logic                        s3_adj_ff,  s3_adj_in;
   logic [ddd_pkg::DAY_W-1:0]   s3_day_ff,  s3_day_in;

   // stage 4: final sum
   logic [ddd_pkg::NUM_W-1:0]   s4_num_ff,  s4_num_in;

   logic [ddd_pkg::YEAR_W-1:0]  year_sat;
   logic [ddd_pkg::YEAR_W-1:0]  cent_part;
   logic [ddd_pkg::QUOT_W-1:0]  r100;
   logic                        leap;
   logic [ddd_pkg::DAY_W-1:0]   day_lim;

   always_comb begin
      if (date_in.year < ddd_pkg::YEAR_MIN) begin
         year_sat = ddd_pkg::YEAR_MIN;
      end else if (date_in.year > ddd_pkg::YEAR_MAX) begin
         year_sat = ddd_pkg::YEAR_MAX;
      end else begin
         year_sat = date_in.year;
      end
      s1_p_in = year_sat - ddd_pkg::YEAR_MIN;
      if (date_in.month < ddd_pkg::MONTH_MIN) begin
         s1_month_in = ddd_pkg::MONTH_MIN;
      end else if (date_in.month > ddd_pkg::MONTH_MAX) begin
         s1_month_in = ddd_pkg::MONTH_MAX;
      end else begin
         s1_month_in = date_in.month;
      end
   end

   assign s2_prod_in = ddd_pkg::DIV100_W'(s1_p_ff) * ddd_pkg::DIV100_MUL;
   assign s2_p365_in = ddd_pkg::NUM_W'(s1_p_ff) * ddd_pkg::DAYS_PER_YEAR;

   always_comb begin
      s3_q100_in = s2_prod_ff[ddd_pkg::DIV100_SHIFT +: ddd_pkg::QUOT_W];
      cent_part  = ddd_pkg::YEAR_W'(s3_q100_in) * 14'd100;
      r100       = ddd_pkg::QUOT_W'(s2_p_ff - cent_part);
      // year = p + 1: divisible by 4 when p mod 4 is 3, by 100 when p mod 100 is 99,
      // by 400 when in addition the century count mod 4 is 3
      leap = ((s2_p_ff[1:0] == 2'd3) && (r100 != ddd_pkg::REM_CENTURY)) ||
             ((r100 == ddd_pkg::REM_CENTURY) && (s3_q100_in[1:0] == 2'd3));
      day_lim = ddd_pkg::month_len(s2_month_ff) +
                ddd_pkg::DAY_W'((s2_month_ff == ddd_pkg::MONTH_FEB) && leap);
      if (s2_day_ff < ddd_pkg::DAY_MIN) begin
         s3_day_in = ddd_pkg::DAY_MIN;
      end else if (s2_day_ff > day_lim) begin
         s3_day_in = day_lim;
      end else begin
         s3_day_in = s2_day_ff;
      end
      s3_base_in = s2_p365_ff + ddd_pkg::NUM_W'(s2_p_ff[ddd_pkg::YEAR_W-1:2]);
      s3_dbm_in  = ddd_pkg::days_before(s2_month_ff);
      s3_adj_in  = leap && (s2_month_ff > ddd_pkg::MONTH_FEB);
   end

   assign s4_num_in = s3_base_ff - ddd_pkg::NUM_W'(s3_q100_ff)
                    + ddd_pkg::NUM_W'(s3_q100_ff[ddd_pkg::QUOT_W-1:2])
                    + ddd_pkg::NUM_W'(s3_dbm_ff) + ddd_pkg::NUM_W'(s3_adj_ff)
                    + ddd_pkg::NUM_W'(s3_day_ff);

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         s1_p_ff     <= s1_p_in;
         s1_month_ff <= s1_month_in;
         s1_day_ff   <= date_in.day;
      end
      if (stage_en.s2) begin
         s2_prod_ff  <= s2_prod_in;
         s2_p365_ff  <= s2_p365_in;
         s2_p_ff     <= s1_p_ff;
         s2_month_ff <= s1_month_ff;
         s2_day_ff   <= s1_day_ff;
      end
      if (stage_en.s3) begin
         s3_q100_ff <= s3_q100_in;
         s3_base_ff <= s3_base_in;
         s3_dbm_ff  <= s3_dbm_in;
         s3_adj_ff  <= s3_adj_in;
         s3_day_ff  <= s3_day_in;
      end
      if (stage_en.s4) begin
         s4_num_ff <= s4_num_in;
      end
   end

   assign day_num = s4_num_ff;

endmodule

### verif/date_difference_days_checker.sv
// ----------------------------------------------------------------------------
// date_difference_days_checker
// Watches the date, result and register ports of the day-count unit. Keeps its
// own copy of the reference date, predicts the inclusive day count and order
// flag for each accepted date, and compares every result beat in order.
// ----------------------------------------------------------------------------
module date_difference_days_checker
   import ddd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [23:0]           req_tdata,   // in_day, in_month, in_year, pad
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [23:0]           rsp_tdata,   // day_count, pad
   input  logic                  rsp_tuser,   // order_error
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [YEAR_W-1:0]     csr_wdata,
   output int                    mismatch_count,
   output int                    pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [NUM_W-1:0] days;
      logic             late;
   } span_type;

   logic [DAY_W-1:0]   end_day   = REF_DAY_RESET;
   logic [MONTH_W-1:0] end_month = REF_MONTH_RESET;
   logic [YEAR_W-1:0]  end_year  = REF_YEAR_RESET;
   span_type           day_spans[$];
   int                 mismatches = 0;

   assign mismatch_count = mismatches;

   function automatic int unsigned days_in_month(input int unsigned m);
      int unsigned n;
      case (m)
         1, 3, 5, 7, 8, 10, 12: n = 31;
         4, 6, 9, 11:           n = 30;
         2:                     n = 28;
         default:               n = 0;
      endcase
      return n;
   endfunction

   // Clamp each field into range, then count days with 0001-01-01 as day 1.
   function automatic int unsigned calendar_ordinal(input logic [DAY_W-1:0] d,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic [YEAR_W-1:0] y);
      int unsigned dd, mm, yy, lim, p, n, k;
      bit          leap;
      yy = 32'(y);
      mm = 32'(m);
      dd = 32'(d);
      if (yy < 1) yy = 1;
      if (yy > 9999) yy = 9999;
      if (mm < 1) mm = 1;
      if (mm > 12) mm = 12;
      leap = ((yy % 4) == 0 && (yy % 100) != 0) || (yy % 400) == 0;
      lim = days_in_month(mm) + ((mm == 2 && leap) ? 1 : 0);
      if (dd < 1) dd = 1;
      if (dd > lim) dd = lim;
      p = yy - 1;
      n = 365 * p + p / 4 - p / 100 + p / 400;
      for (k = 1; k < mm; k++) n += days_in_month(k);
      if (mm > 2 && leap) n += 1;
      return n + dd;
   endfunction

   function automatic span_type predict_span(input logic [23:0] beat);
      int unsigned first, last;
      span_type    s;
      first = calendar_ordinal(beat[4:0], beat[8:5], beat[22:9]);
      last  = calendar_ordinal(end_day, end_month, end_year);
      if (first > last) begin
         s.days = '0;
         s.late = 1'b1;
      end else begin
         s.days = NUM_W'(last - first + 1);
         s.late = 1'b0;
      end
      return s;
   endfunction

   always @(posedge clock) begin
      span_type want;
      if (reset) begin
         end_day   = REF_DAY_RESET;
         end_month = REF_MONTH_RESET;
         end_year  = REF_YEAR_RESET;
         day_spans.delete();
         pending_results <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_REF_DAY:   end_day   = csr_wdata[DAY_W-1:0];
               CSR_REF_MONTH: end_month = csr_wdata[MONTH_W-1:0];
               CSR_REF_YEAR:  end_year  = csr_wdata[YEAR_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (day_spans.size() == 0) begin
               $display("%0t: result beat with none expected, day_count %0d order_error %0b",
                        $time, rsp_tdata[NUM_W-1:0], rsp_tuser);
               mismatches++;
            end else begin
               want = day_spans.pop_front();
               if (rsp_tdata[NUM_W-1:0] !== want.days) begin
                  $display("%0t: day_count mismatch, expected %0d, got %0d",
                           $time, want.days, rsp_tdata[NUM_W-1:0]);
                  mismatches++;
               end
               if (rsp_tuser !== want.late) begin
                  $display("%0t: order_error mismatch, expected %0b, got %0b",
                           $time, want.late, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) day_spans.push_back(predict_span(req_tdata));
         pending_results <= day_spans.size();
      end
   end

endmodule

### verif/tb_date_difference_days_unit.sv
// ----------------------------------------------------------------------------
// tb_date_difference_days_unit
// Streams start dates into the day-count unit: a directed set of calendar
// corners, then random dates under several reference dates written between
// phases. Both stream sides idle at random; one long result stall backs the
// pipe up. The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_date_difference_days_unit;
   import ddd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT    = 2000;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int PHASE_DATES    = 200;
   localparam int RANDOM_PHASES  = 6;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata  = '0;   // in_day, in_month, in_year, pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;         // day_count, pad
   logic                  rsp_tuser;         // order_error
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [YEAR_W-1:0]     csr_wdata  = '0;

   int  mismatch_count;
   int  pending_results;
   bit  idling           = 1'b1;
   bit  hold_off_request = 1'b0;

   // raw values last written to the reference registers
   logic [DAY_W-1:0]   end_day   = REF_DAY_RESET;
   logic [MONTH_W-1:0] end_month = REF_MONTH_RESET;
   logic [YEAR_W-1:0]  end_year  = REF_YEAR_RESET;

   date_difference_days_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   date_difference_days_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: random back-pressure, plus one long hold-off on request
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_tready       <= 1'b0;
            hold_off_request <= 1'b0;
            for (hold = 0; hold < HOLD_OFF_LEN; hold++) @(posedge clock);
         end else begin
            rsp_tready <= !idling || ($urandom_range(99) >= 31);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                            input logic [YEAR_W-1:0] y);
      while (idling && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, y, m, d};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and wait until every result has drained
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic set_reference(input logic [YEAR_W-1:0] d, input logic [YEAR_W-1:0] m,
                                input logic [YEAR_W-1:0] y);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_REF_DAY;
      csr_wdata <= d;
      @(posedge clock);
      csr_addr  <= CSR_REF_MONTH;
      csr_wdata <= m;
      @(posedge clock);
      csr_addr  <= CSR_REF_YEAR;
      csr_wdata <= y;
      @(posedge clock);
      csr_we    <= 1'b0;
      end_day   = d[DAY_W-1:0];
      end_month = m[MONTH_W-1:0];
      end_year  = y;
   endtask

   // mostly valid dates, some close to the reference, some raw bit patterns
   task automatic send_random_date();
      logic [DAY_W-1:0]   d;
      logic [MONTH_W-1:0] m;
      logic [YEAR_W-1:0]  y;
      logic [31:0]        raw;
      int                 pick;
      pick = $urandom_range(99);
      raw  = $urandom;
      if (pick < 55) begin
         y = YEAR_W'($urandom_range(9999, 1));
         m = MONTH_W'($urandom_range(12, 1));
         d = DAY_W'($urandom_range(31, 1));
      end else if (pick < 80) begin
         y = end_year + YEAR_W'($urandom_range(2)) - YEAR_W'(1);
         if ($urandom_range(3) != 0) y = end_year;
         m = ($urandom_range(1) != 0) ? end_month : MONTH_W'($urandom_range(12, 1));
         d = DAY_W'($urandom_range(31));
      end else begin
         {y, m, d} = raw[22:0];
      end
      send_date(d, m, y);
   endtask

   initial begin
      int phase, n;
      logic [YEAR_W-1:0] rd, rm, ry;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reference at reset: 2020-09-17
      send_date(5'd17, 4'd9, 14'd2020);
      send_date(5'd18, 4'd9, 14'd2020);
      send_date(5'd16, 4'd9, 14'd2020);
      send_date(5'd1, 4'd9, 14'd2020);
      send_date(5'd1, 4'd1, 14'd1);
      send_date(5'd0, 4'd0, 14'd0);
      send_date(5'd31, 4'd15, 14'd16383);
      send_date(5'd31, 4'd12, 14'd9999);
      send_date(5'd29, 4'd2, 14'd2020);
      send_date(5'd29, 4'd2, 14'd2019);
      send_date(5'd29, 4'd2, 14'd1900);
      send_date(5'd30, 4'd2, 14'd2000);
      send_date(5'd31, 4'd4, 14'd2020);
      send_date(5'd0, 4'd13, 14'd2020);
      send_date(5'd31, 4'd12, 14'd2019);
      send_date(5'd1, 4'd3, 14'd2020);
      send_date(5'h15, 4'ha, 14'h2aaa);
      send_date(5'h0a, 4'h5, 14'h1555);

      // latest possible reference
      drain_results();
      set_reference(14'd31, 14'd12, 14'd9999);
      send_date(5'd1, 4'd1, 14'd1);
      send_date(5'd31, 4'd12, 14'd9999);
      send_date(5'd31, 4'd15, 14'd16383);

      // reference of all zeros clamps to the first day; high data bits unused
      drain_results();
      set_reference(14'h3fe0, 14'h3ff0, 14'd0);
      send_date(5'd1, 4'd1, 14'd1);
      send_date(5'd0, 4'd0, 14'd0);
      send_date(5'd2, 4'd1, 14'd1);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         rd = YEAR_W'($urandom_range(31, 1));
         rm = YEAR_W'($urandom_range(12, 1));
         ry = YEAR_W'($urandom_range(9999, 1));
         case (phase)
            1: begin
               rd = 14'd29;
               rm = 14'd2;
               ry = 14'd2000;
            end
            3: begin
               rd = YEAR_W'($urandom_range(16383));
               rm = YEAR_W'($urandom_range(16383));
               ry = YEAR_W'($urandom_range(16383));
            end
            4: begin
               rd = 14'd31;
               rm = 14'd12;
               ry = 14'd9999;
            end
            default: ;
         endcase
         set_reference(rd, rm, ry);
         idling <= (phase != 3);
         for (n = 0; n < PHASE_DATES; n++) begin
            if (phase == 2 && n == 20) hold_off_request <= 1'b1;
            send_random_date();
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
